[rtl/assert_macros.svh]
// Assertion macros shared by the checker files of the QM encoder.
// Depends on nothing; each macro expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while in reset
`define QMAE_ASSERT_IMP(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("qm encoder port check failed");

// Next-cycle implication, sampled on clk, off while in reset
`define QMAE_ASSERT_NEXT(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("qm encoder port check failed");

`endif

[rtl/qmae_pkg.sv]
// Shared types, constants and tables of the QM binary arithmetic encoder.
// Depends on nothing; used by every module of the block.
package qmae_pkg;

    localparam int NUM_CONTEXTS_DEF    = 256;
    localparam int RUN_COUNT_WIDTH_DEF = 16;
    localparam int REPEAT_W            = 16;
    localparam int FRONT_DEPTH         = 4;
    localparam int OUTQ_DEPTH          = 8;
    localparam int RUN_MAX             = 6;
    localparam int QM_ROWS             = 113;

    localparam logic [0:0]  OP_ENCODE = 1'b0;
    localparam logic [0:0]  OP_FINISH = 1'b1;
    localparam logic [16:0] A_INIT    = 17'h10000;
    localparam logic [16:0] A_HALF    = 17'h08000;
    localparam logic [3:0]  CT_INIT   = 4'd11;
    localparam logic [8:0]  NO_BYTE   = 9'h1FF;

    typedef struct packed {
        logic [0:0] op;
        logic [7:0] ctx_index;
        logic       bit_req;
    } in_item_t;

    typedef struct packed {
        logic [7:0]          out_byte;
        logic                stuff_zero;
        logic [REPEAT_W-1:0] repeat_count;
        logic                count_overflow;
        logic                last;
    } out_item_t;

    typedef enum logic [1:0] {
        CMD_ENCODE,
        CMD_FINISH,
        CMD_SKIP
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] ctx;
        logic       bit_req;
    } cmd_t;

    typedef enum logic [4:0] {
        CS_CLEAR,
        CS_IDLE,
        CS_SUB,
        CS_UPD,
        CS_REN,
        CS_BYTE,
        CS_REL_A,
        CS_REL_B,
        CS_REL_C,
        CS_REL_D,
        CS_REL_E,
        CS_FIN_ADD,
        CS_FIN_ADJ,
        CS_FIN_SHIFT,
        CS_FIN_Z,
        CS_FIN_B1,
        CS_FIN_B2,
        CS_DRAIN
    } core_state_t;

    typedef struct packed {
        logic [15:0] qe;
        logic [6:0]  nlps;
        logic [6:0]  nmps;
        logic        sw;
    } qm_row_t;

    // Qe value, next index after LPS, next index after MPS, MPS switch
    localparam qm_row_t QM_ROM [QM_ROWS] = '{
        '{16'h5a1d,7'd1,7'd1,1'b1},   '{16'h2586,7'd14,7'd2,1'b0},
        '{16'h1114,7'd16,7'd3,1'b0},  '{16'h080b,7'd18,7'd4,1'b0},
        '{16'h03d8,7'd20,7'd5,1'b0},  '{16'h01da,7'd23,7'd6,1'b0},
        '{16'h00e5,7'd25,7'd7,1'b0},  '{16'h006f,7'd28,7'd8,1'b0},
        '{16'h0036,7'd30,7'd9,1'b0},  '{16'h001a,7'd33,7'd10,1'b0},
        '{16'h000d,7'd35,7'd11,1'b0}, '{16'h0006,7'd9,7'd12,1'b0},
        '{16'h0003,7'd10,7'd13,1'b0}, '{16'h0001,7'd12,7'd13,1'b0},
        '{16'h5a7f,7'd15,7'd15,1'b1}, '{16'h3f25,7'd36,7'd16,1'b0},
        '{16'h2cf2,7'd38,7'd17,1'b0}, '{16'h207c,7'd39,7'd18,1'b0},
        '{16'h17b9,7'd40,7'd19,1'b0}, '{16'h1182,7'd42,7'd20,1'b0},
        '{16'h0cef,7'd43,7'd21,1'b0}, '{16'h09a1,7'd45,7'd22,1'b0},
        '{16'h072f,7'd46,7'd23,1'b0}, '{16'h055c,7'd48,7'd24,1'b0},
        '{16'h0406,7'd49,7'd25,1'b0}, '{16'h0303,7'd51,7'd26,1'b0},
        '{16'h0240,7'd52,7'd27,1'b0}, '{16'h01b1,7'd54,7'd28,1'b0},
        '{16'h0144,7'd56,7'd29,1'b0}, '{16'h00f5,7'd57,7'd30,1'b0},
        '{16'h00b7,7'd59,7'd31,1'b0}, '{16'h008a,7'd60,7'd32,1'b0},
        '{16'h0068,7'd62,7'd33,1'b0}, '{16'h004e,7'd63,7'd34,1'b0},
        '{16'h003b,7'd32,7'd35,1'b0}, '{16'h002c,7'd33,7'd9,1'b0},
        '{16'h5ae1,7'd37,7'd37,1'b1}, '{16'h484c,7'd64,7'd38,1'b0},
        '{16'h3a0d,7'd65,7'd39,1'b0}, '{16'h2ef1,7'd67,7'd40,1'b0},
        '{16'h261f,7'd68,7'd41,1'b0}, '{16'h1f33,7'd69,7'd42,1'b0},
        '{16'h19a8,7'd70,7'd43,1'b0}, '{16'h1518,7'd72,7'd44,1'b0},
        '{16'h1177,7'd73,7'd45,1'b0}, '{16'h0e74,7'd74,7'd46,1'b0},
        '{16'h0bfb,7'd75,7'd47,1'b0}, '{16'h09f8,7'd77,7'd48,1'b0},
        '{16'h0861,7'd78,7'd49,1'b0}, '{16'h0706,7'd79,7'd50,1'b0},
        '{16'h05cd,7'd48,7'd51,1'b0}, '{16'h04de,7'd50,7'd52,1'b0},
        '{16'h040f,7'd50,7'd53,1'b0}, '{16'h0363,7'd51,7'd54,1'b0},
        '{16'h02d4,7'd52,7'd55,1'b0}, '{16'h025c,7'd53,7'd56,1'b0},
        '{16'h01f8,7'd54,7'd57,1'b0}, '{16'h01a4,7'd55,7'd58,1'b0},
        '{16'h0160,7'd56,7'd59,1'b0}, '{16'h0125,7'd57,7'd60,1'b0},
        '{16'h00f6,7'd58,7'd61,1'b0}, '{16'h00cb,7'd59,7'd62,1'b0},
        '{16'h00ab,7'd61,7'd63,1'b0}, '{16'h008f,7'd61,7'd32,1'b0},
        '{16'h5b12,7'd65,7'd65,1'b1}, '{16'h4d04,7'd80,7'd66,1'b0},
        '{16'h412c,7'd81,7'd67,1'b0}, '{16'h37d8,7'd82,7'd68,1'b0},
        '{16'h2fe8,7'd83,7'd69,1'b0}, '{16'h293c,7'd84,7'd70,1'b0},
        '{16'h2379,7'd86,7'd71,1'b0}, '{16'h1edf,7'd87,7'd72,1'b0},
        '{16'h1aa9,7'd87,7'd73,1'b0}, '{16'h174e,7'd72,7'd74,1'b0},
        '{16'h1424,7'd72,7'd75,1'b0}, '{16'h119c,7'd74,7'd76,1'b0},
        '{16'h0f6b,7'd74,7'd77,1'b0}, '{16'h0d51,7'd75,7'd78,1'b0},
        '{16'h0bb6,7'd77,7'd79,1'b0}, '{16'h0a40,7'd77,7'd48,1'b0},
        '{16'h5832,7'd80,7'd81,1'b1}, '{16'h4d1c,7'd88,7'd82,1'b0},
        '{16'h438e,7'd89,7'd83,1'b0}, '{16'h3bdd,7'd90,7'd84,1'b0},
        '{16'h34ee,7'd91,7'd85,1'b0}, '{16'h2eae,7'd92,7'd86,1'b0},
        '{16'h299a,7'd93,7'd87,1'b0}, '{16'h2516,7'd86,7'd71,1'b0},
        '{16'h5570,7'd88,7'd89,1'b1}, '{16'h4ca9,7'd95,7'd90,1'b0},
        '{16'h44d9,7'd96,7'd91,1'b0}, '{16'h3e22,7'd97,7'd92,1'b0},
        '{16'h3824,7'd99,7'd93,1'b0}, '{16'h32b4,7'd99,7'd94,1'b0},
        '{16'h2e17,7'd93,7'd86,1'b0}, '{16'h56a8,7'd95,7'd96,1'b1},
        '{16'h4f46,7'd101,7'd97,1'b0}, '{16'h47e5,7'd102,7'd98,1'b0},
        '{16'h41cf,7'd103,7'd99,1'b0}, '{16'h3c3d,7'd104,7'd100,1'b0},
        '{16'h375e,7'd99,7'd93,1'b0}, '{16'h5231,7'd105,7'd102,1'b0},
        '{16'h4c0f,7'd106,7'd103,1'b0}, '{16'h4639,7'd107,7'd104,1'b0},
        '{16'h415e,7'd103,7'd99,1'b0}, '{16'h5627,7'd105,7'd106,1'b1},
        '{16'h50e7,7'd108,7'd107,1'b0}, '{16'h4b85,7'd109,7'd103,1'b0},
        '{16'h5597,7'd110,7'd109,1'b0}, '{16'h504f,7'd111,7'd107,1'b0},
        '{16'h5a10,7'd110,7'd111,1'b1}, '{16'h5522,7'd112,7'd109,1'b0},
        '{16'h59eb,7'd112,7'd111,1'b1}
    };

    // Shift count that brings a nonzero A below one half up to bit 15
    function automatic logic [3:0] renorm_shift(input logic [15:0] a);
        logic [3:0] s;
        s = 4'd15;
        for (int i = 0; i < 15; i++) begin
            if (a[i]) begin
                s = 4'(15 - i);
            end
        end
        return s;
    endfunction

endpackage

[rtl/qmae_front.sv]
// Front part of the QM encoder: accepts input items, classifies them and
// queues commands for the coder core. Depends on qmae_pkg.
module qmae_front #(
    parameter int NUM_CONTEXTS = qmae_pkg::NUM_CONTEXTS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  qmae_pkg::in_item_t item,
    input  logic              hold,
    output logic              full,
    output logic              cmd_valid,
    output qmae_pkg::cmd_t    cmd,
    input  logic              cmd_pop
);
    import qmae_pkg::*;

    localparam int AW = $clog2(FRONT_DEPTH);

    cmd_t            slot_mem [FRONT_DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [AW:0]     count_reg, count_next;
    cmd_t            cls;
    logic [12:0]     ctx_ext;
    logic            accept;
    logic            enq;
    logic            deq;

    // Classify: finish, in-range encode, or drop
    assign ctx_ext = {5'd0, item.ctx_index};
    always_comb
    begin
        cls.ctx     = item.ctx_index;
        cls.bit_req = item.bit_req;
        unique case (item.op)
            OP_FINISH: cls.kind = CMD_FINISH;
            default:   cls.kind = (ctx_ext < 13'(NUM_CONTEXTS)) ? CMD_ENCODE : CMD_SKIP;
        endcase
    end

    assign full      = hold || (count_reg == (AW+1)'(FRONT_DEPTH));
    assign accept    = push && !full;
    assign enq       = accept && (cls.kind != CMD_SKIP);
    assign cmd_valid = count_reg != '0;
    assign deq       = cmd_pop && cmd_valid;
    assign cmd       = slot_mem[rd_ptr_reg];

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = enq ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = deq ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (enq && !deq)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!enq && deq)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store queued commands
    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            slot_mem[wr_ptr_reg] <= cls;
        end
    end

endmodule

[rtl/qmae_outq.sv]
// Result queue of the QM encoder: holds finished runs until they are popped.
// Depends on qmae_pkg.
module qmae_outq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr,
    input  qmae_pkg::out_item_t wdata,
    output logic                wfull,
    output logic                empty,
    input  logic                pop,
    output qmae_pkg::out_item_t result
);
    import qmae_pkg::*;

    localparam int AW = $clog2(OUTQ_DEPTH);

    out_item_t      slot_mem [OUTQ_DEPTH];
    logic [AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [AW:0]    count_reg, count_next;
    logic           enq;
    logic           deq;

    assign wfull  = count_reg == (AW+1)'(OUTQ_DEPTH);
    assign empty  = count_reg == '0;
    assign enq    = wr && !wfull;
    assign deq    = pop && !empty;
    assign result = slot_mem[rd_ptr_reg];

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = enq ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = deq ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (enq && !deq)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!enq && deq)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store runs
    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            slot_mem[wr_ptr_reg] <= wdata;
        end
    end

endmodule

[rtl/qmae_core.sv]
// Back part of the QM encoder: context store, A/C arithmetic, renormalization,
// byte output with carry, 0xFF stacking and zero runs. Depends on qmae_pkg.
module qmae_core #(
    parameter int NUM_CONTEXTS    = qmae_pkg::NUM_CONTEXTS_DEF,
    parameter int RUN_COUNT_WIDTH = qmae_pkg::RUN_COUNT_WIDTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    input  qmae_pkg::cmd_t      cmd,
    output logic                cmd_pop,
    output logic                clearing,
    output logic                oq_wr,
    output qmae_pkg::out_item_t oq_data,
    input  logic                oq_full
);
    import qmae_pkg::*;

    localparam int CTX_W = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;
    localparam int CNT_W = (RUN_COUNT_WIDTH > 16) ? 16 : RUN_COUNT_WIDTH;

    core_state_t       state_reg, state_next;
    logic [16:0]       a_reg, a_next;
    logic [27:0]       c_reg, c_next;
    logic [3:0]        ct_reg, ct_next;
    logic [8:0]        held_reg, held_next;
    logic [CNT_W-1:0]  ff_reg, ff_next;
    logic [CNT_W-1:0]  pz_reg, pz_next;
    logic              ovf_reg, ovf_next;
    logic [CTX_W-1:0]  clr_idx_reg, clr_idx_next;
    logic [2:0]        run_cnt_reg, run_cnt_next;
    logic [2:0]        drain_idx_reg, drain_idx_next;
    logic              carry_reg, carry_next;
    logic              rel_fin_reg, rel_fin_next;
    cmd_t              cmd_reg, cmd_next;
    qm_row_t           row_reg, row_next;
    logic [16:0]       a1_reg, a1_next;
    logic [7:0]        hold_byte_reg, hold_byte_next;
    logic [31:0]       fin_c_reg, fin_c_next;
    logic [7:0]        rd_data_reg;

    logic [7:0]        ctx_mem [NUM_CONTEXTS];
    logic [7:0]        run_byte_mem [RUN_MAX];
    logic [CNT_W-1:0]  run_len_mem [RUN_MAX];

    logic [CTX_W+7:0]  ctx_ext;
    logic [CTX_W-1:0]  ctx_addr;
    logic              mem_we;
    logic [CTX_W-1:0]  mem_waddr;
    logic [7:0]        mem_wdata;
    logic              rd_en;

    logic              push_run;
    logic [7:0]        push_byte;
    logic [CNT_W-1:0]  push_len;
    logic              run_wr;

    logic [6:0]        rom_idx;
    logic              have;
    logic              pz_nz;
    logic              ff_nz;
    logic              is_lps;
    logic              a1_ge_qe;
    logic              ren_go;
    logic [3:0]        lz;
    logic [3:0]        shift_s;
    logic [3:0]        ct_after;
    logic [8:0]        byte_t;
    logic              fin_hi;
    logic              fin_lo;
    logic [31:0]       fin_shifted;
    logic [CNT_W:0]    pz_inc;
    logic [CNT_W:0]    pz_add_ff;
    logic [CNT_W:0]    ff_inc;
    logic              drain_last;

    // Helper terms
    assign ctx_ext     = {{CTX_W{1'b0}}, cmd.ctx};
    assign ctx_addr    = ctx_ext[CTX_W-1:0];
    assign rom_idx     = (rd_data_reg[6:0] >= 7'(QM_ROWS)) ? 7'(QM_ROWS - 1) : rd_data_reg[6:0];
    assign have        = !held_reg[8];
    assign pz_nz       = pz_reg != '0;
    assign ff_nz       = ff_reg != '0;
    assign is_lps      = cmd_reg.bit_req != rd_data_reg[7];
    assign a1_ge_qe    = a1_reg >= {1'b0, row_reg.qe};
    assign ren_go      = (a_reg < A_HALF) && (a_reg != '0);
    assign lz          = renorm_shift(a_reg[15:0]);
    assign shift_s     = (lz < ct_reg) ? lz : ct_reg;
    assign ct_after    = ct_reg - shift_s;
    assign byte_t      = c_reg[27:19];
    assign fin_hi      = fin_c_reg[26:11] != '0;
    assign fin_lo      = fin_c_reg[18:11] != '0;
    assign fin_shifted = fin_c_reg << ct_reg;
    assign pz_inc      = {1'b0, pz_reg} + 1'b1;
    assign pz_add_ff   = {1'b0, pz_reg} + {1'b0, ff_reg};
    assign ff_inc      = {1'b0, ff_reg} + 1'b1;
    assign drain_last  = drain_idx_reg == 3'(run_cnt_reg - 3'd1);
    assign run_wr      = push_run && (run_cnt_reg != 3'(RUN_MAX));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            CS_CLEAR:
                if (clr_idx_reg == CTX_W'(NUM_CONTEXTS - 1)) state_next = CS_IDLE;
            CS_IDLE:
                if (cmd_valid) state_next = (cmd.kind == CMD_FINISH) ? CS_FIN_ADD : CS_SUB;
            CS_SUB:
                state_next = CS_UPD;
            CS_UPD:
                state_next = (!is_lps && (a1_reg >= A_HALF)) ? CS_DRAIN : CS_REN;
            CS_REN:
                if (!ren_go) state_next = CS_DRAIN;
                else if (ct_after == '0) state_next = CS_BYTE;
            CS_BYTE:
                state_next = (byte_t == 9'h0FF) ? CS_REN : CS_REL_A;
            CS_REL_A:
                if (carry_reg) state_next = have ? CS_REL_B : CS_REL_C;
                else state_next = (have && held_reg[7:0] != '0) ? CS_REL_B : CS_REL_D;
            CS_REL_B:
                state_next = carry_reg ? CS_REL_C : CS_REL_D;
            CS_REL_C, CS_REL_E:
                state_next = rel_fin_reg ? CS_FIN_Z : CS_REN;
            CS_REL_D:
                state_next = CS_REL_E;
            CS_FIN_ADD:
                state_next = CS_FIN_ADJ;
            CS_FIN_ADJ:
                state_next = CS_FIN_SHIFT;
            CS_FIN_SHIFT:
                state_next = CS_REL_A;
            CS_FIN_Z:
                state_next = CS_FIN_B1;
            CS_FIN_B1:
                state_next = CS_FIN_B2;
            CS_FIN_B2:
                state_next = CS_DRAIN;
            CS_DRAIN:
                if (run_cnt_reg == '0) state_next = CS_IDLE;
                else if (!oq_full && drain_last) state_next = CS_IDLE;
            default:
                state_next = CS_IDLE;
        endcase
    end

    // Outputs and datapath next values
    always_comb
    begin
        a_next         = a_reg;
        c_next         = c_reg;
        ct_next        = ct_reg;
        held_next      = held_reg;
        ff_next        = ff_reg;
        pz_next        = pz_reg;
        ovf_next       = ovf_reg;
        clr_idx_next   = clr_idx_reg;
        run_cnt_next   = run_cnt_reg;
        drain_idx_next = drain_idx_reg;
        carry_next     = carry_reg;
        rel_fin_next   = rel_fin_reg;
        cmd_next       = cmd_reg;
        row_next       = row_reg;
        a1_next        = a1_reg;
        hold_byte_next = hold_byte_reg;
        fin_c_next     = fin_c_reg;
        mem_we         = 1'b0;
        mem_waddr      = CTX_W'(cmd_reg.ctx);
        mem_wdata      = '0;
        rd_en          = 1'b0;
        cmd_pop        = 1'b0;
        push_run       = 1'b0;
        push_byte      = '0;
        push_len       = '0;
        oq_wr          = 1'b0;
        oq_data        = '0;
        clearing       = 1'b0;

        unique case (state_reg)
            // Sweep the context store to zero after reset
            CS_CLEAR:
            begin
                clearing     = 1'b1;
                mem_we       = 1'b1;
                mem_waddr    = clr_idx_reg;
                clr_idx_next = clr_idx_reg + 1'b1;
            end
            // Take the next command and read its context
            CS_IDLE:
            begin
                cmd_pop = cmd_valid;
                rd_en   = cmd_valid;
                if (cmd_valid)
                begin
                    cmd_next       = cmd;
                    run_cnt_next   = '0;
                    drain_idx_next = '0;
                end
            end
            // Look up the probability row, split the interval
            CS_SUB:
            begin
                row_next = QM_ROM[rom_idx];
                a1_next  = a_reg - {1'b0, QM_ROM[rom_idx].qe};
            end
            // Conditional exchange and context update
            CS_UPD:
            begin
                if (is_lps)
                begin
                    if (a1_ge_qe)
                    begin
                        c_next = c_reg + 28'(a1_reg);
                        a_next = {1'b0, row_reg.qe};
                    end
                    else
                    begin
                        a_next = a1_reg;
                    end
                    mem_we    = 1'b1;
                    mem_wdata = {rd_data_reg[7] ^ row_reg.sw, row_reg.nlps};
                end
                else
                begin
                    a_next = a1_reg;
                    if (a1_reg < A_HALF)
                    begin
                        if (!a1_ge_qe)
                        begin
                            c_next = c_reg + 28'(a1_reg);
                            a_next = {1'b0, row_reg.qe};
                        end
                        mem_we    = 1'b1;
                        mem_wdata = {rd_data_reg[7], row_reg.nmps};
                    end
                end
            end
            // Shift up to the next byte boundary
            CS_REN:
            begin
                if (ren_go)
                begin
                    a_next  = a_reg << shift_s;
                    c_next  = c_reg << shift_s;
                    ct_next = ct_after;
                end
            end
            // Take a finished byte from C
            CS_BYTE:
            begin
                c_next         = {9'd0, c_reg[18:0]};
                ct_next        = ct_reg + 4'd8;
                carry_next     = byte_t[8];
                hold_byte_next = byte_t[7:0];
                rel_fin_next   = 1'b0;
                if (byte_t == 9'h0FF)
                begin
                    ff_next = ff_inc[CNT_W] ? '1 : ff_inc[CNT_W-1:0];
                    ovf_next = ovf_reg | ff_inc[CNT_W];
                end
            end
            // Release: flush pending zeros or count a held zero byte
            CS_REL_A:
            begin
                if (!carry_reg && have && held_reg[7:0] == '0)
                begin
                    pz_next  = pz_inc[CNT_W] ? '1 : pz_inc[CNT_W-1:0];
                    ovf_next = ovf_reg | pz_inc[CNT_W];
                end
                else if (have && pz_nz)
                begin
                    push_run = 1'b1;
                    push_len = pz_reg;
                    pz_next  = '0;
                end
            end
            // Release: emit the held byte, plus carry
            CS_REL_B:
            begin
                push_run  = 1'b1;
                push_byte = carry_reg ? held_reg[7:0] + 8'd1 : held_reg[7:0];
                push_len  = CNT_W'(1);
            end
            // Release with carry: stacked 0xFF bytes become zeros
            CS_REL_C:
            begin
                pz_next  = pz_add_ff[CNT_W] ? '1 : pz_add_ff[CNT_W-1:0];
                ovf_next = ovf_reg | pz_add_ff[CNT_W];
                ff_next  = '0;
                if (!rel_fin_reg) held_next = {1'b0, hold_byte_reg};
            end
            // Release without carry: flush zeros ahead of the 0xFF run
            CS_REL_D:
            begin
                if (ff_nz && pz_nz)
                begin
                    push_run = 1'b1;
                    push_len = pz_reg;
                    pz_next  = '0;
                end
            end
            // Release without carry: emit the 0xFF run
            CS_REL_E:
            begin
                if (ff_nz)
                begin
                    push_run  = 1'b1;
                    push_byte = 8'hFF;
                    push_len  = ff_reg;
                    ff_next   = '0;
                end
                if (!rel_fin_reg) held_next = {1'b0, hold_byte_reg};
            end
            // Termination: place C inside the final interval
            CS_FIN_ADD:
            begin
                fin_c_next = (32'(a_reg) - 32'd1 + 32'(c_reg)) & 32'hFFFF0000;
            end
            CS_FIN_ADJ:
            begin
                if (fin_c_reg < 32'(c_reg)) fin_c_next = fin_c_reg + 32'h8000;
            end
            CS_FIN_SHIFT:
            begin
                fin_c_next   = fin_shifted;
                carry_next   = fin_shifted[31:27] != '0;
                rel_fin_next = 1'b1;
            end
            // Termination: flush zeros before the last bytes
            CS_FIN_Z:
            begin
                if (fin_hi && pz_nz)
                begin
                    push_run = 1'b1;
                    push_len = pz_reg;
                    pz_next  = '0;
                end
            end
            CS_FIN_B1:
            begin
                if (fin_hi)
                begin
                    push_run  = 1'b1;
                    push_byte = fin_c_reg[26:19];
                    push_len  = CNT_W'(1);
                end
            end
            // Termination: last byte, then re-initialize the coder
            CS_FIN_B2:
            begin
                if (fin_hi && fin_lo)
                begin
                    push_run  = 1'b1;
                    push_byte = fin_c_reg[18:11];
                    push_len  = CNT_W'(1);
                end
                a_next    = A_INIT;
                c_next    = '0;
                ct_next   = CT_INIT;
                held_next = NO_BYTE;
                ff_next   = '0;
                pz_next   = '0;
            end
            // Hand the collected runs to the result queue
            CS_DRAIN:
            begin
                if (run_cnt_reg != '0 && !oq_full)
                begin
                    oq_wr                  = 1'b1;
                    oq_data.out_byte       = run_byte_mem[drain_idx_reg];
                    oq_data.stuff_zero     = run_byte_mem[drain_idx_reg] == 8'hFF;
                    oq_data.repeat_count   = REPEAT_W'(run_len_mem[drain_idx_reg]);
                    oq_data.count_overflow = ovf_reg;
                    oq_data.last           = drain_last;
                    drain_idx_next         = drain_idx_reg + 3'd1;
                end
            end
            default:
            begin
                clearing = 1'b0;
            end
        endcase

        if (run_wr)
        begin
            run_cnt_next = run_cnt_reg + 3'd1;
        end
    end

    // Control and coder registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= CS_CLEAR;
            a_reg         <= A_INIT;
            c_reg         <= '0;
            ct_reg        <= CT_INIT;
            held_reg      <= NO_BYTE;
            ff_reg        <= '0;
            pz_reg        <= '0;
            ovf_reg       <= 1'b0;
            clr_idx_reg   <= '0;
            run_cnt_reg   <= '0;
            drain_idx_reg <= '0;
            carry_reg     <= 1'b0;
            rel_fin_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            a_reg         <= a_next;
            c_reg         <= c_next;
            ct_reg        <= ct_next;
            held_reg      <= held_next;
            ff_reg        <= ff_next;
            pz_reg        <= pz_next;
            ovf_reg       <= ovf_next;
            clr_idx_reg   <= clr_idx_next;
            run_cnt_reg   <= run_cnt_next;
            drain_idx_reg <= drain_idx_next;
            carry_reg     <= carry_next;
            rel_fin_reg   <= rel_fin_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        row_reg       <= row_next;
        a1_reg        <= a1_next;
        hold_byte_reg <= hold_byte_next;
        fin_c_reg     <= fin_c_next;
    end

    // Context store, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ctx_mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= ctx_mem[ctx_addr];
        end
    end

    // Run buffer for the item in progress
    always_ff @(posedge clk)
    begin
        if (run_wr)
        begin
            run_byte_mem[run_cnt_reg] <= push_byte;
            run_len_mem[run_cnt_reg]  <= push_len;
        end
    end

endmodule

[rtl/qm_binary_arith_encoder.sv]
// Top level of the QM binary arithmetic encoder (encoder side only).
// Depends on qmae_pkg, qmae_front, qmae_core and qmae_outq.

// Codes binary decisions in up to NUM_CONTEXTS adaptive contexts and emits
// the compressed stream as runs (byte, stuffing flag, repeat count). After
// reset the block sweeps its context store to zero and holds full high
// meanwhile. Items are processed one at a time by the coder core: an encode
// item reads its context, splits the interval and, where needed, updates the
// context; an MPS path that needs no renormalization ends there. Otherwise
// come shift steps (each step shifts A and C up to the next byte boundary, so
// one or two steps for most items), a final step that ends the renormalization,
// and for each byte taken out of C either a stacked 0xFF or the serial
// carry/zero-run release. A finish item places C in the final interval, then
// releases and writes the last bytes. Results move into the 8-entry result
// queue at one per cycle while it is not full; a 4-entry command queue in front keeps accepting items meanwhile.
// count_overflow on a result reflects the sticky flag after its whole item
// has been processed.
module qm_binary_arith_encoder #(
    parameter int NUM_CONTEXTS    = qmae_pkg::NUM_CONTEXTS_DEF,
    parameter int RUN_COUNT_WIDTH = qmae_pkg::RUN_COUNT_WIDTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  qmae_pkg::in_item_t  item,
    output logic                full,
    output logic                empty,
    input  logic                pop,
    output qmae_pkg::out_item_t result
);
    import qmae_pkg::*;

    logic      cmd_valid;
    cmd_t      cmd;
    logic      cmd_pop;
    logic      clearing;
    logic      oq_wr;
    out_item_t oq_data;
    logic      oq_full;

    // Accept and classify items
    qmae_front #(
        .NUM_CONTEXTS (NUM_CONTEXTS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .item      (item),
        .hold      (clearing),
        .full      (full),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    // Carry out the coding
    qmae_core #(
        .NUM_CONTEXTS    (NUM_CONTEXTS),
        .RUN_COUNT_WIDTH (RUN_COUNT_WIDTH)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .clearing  (clearing),
        .oq_wr     (oq_wr),
        .oq_data   (oq_data),
        .oq_full   (oq_full)
    );

    // Hold results until popped
    qmae_outq u_outq (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (oq_wr),
        .wdata  (oq_data),
        .wfull  (oq_full),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

endmodule

[rtl/qmae_checker.sv]
// Port checker of the QM encoder, bound to the top level.
// Depends on qmae_pkg and assert_macros.svh.
`include "assert_macros.svh"

module qmae_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                empty,
    input logic                pop,
    input qmae_pkg::out_item_t result
);
    import qmae_pkg::*;

    // Stuffing goes with 0xFF runs only
    `QMAE_ASSERT_IMP(a_stuff_ff, !empty, result.stuff_zero == (result.out_byte == 8'hFF))
    // A run is never empty
    `QMAE_ASSERT_IMP(a_count_nz, !empty, result.repeat_count != '0)
    // Overflow flag stays once shown
    `QMAE_ASSERT_IMP(a_ovf_sticky, !empty && $past(!empty && pop && result.count_overflow), result.count_overflow)
    // A waiting result holds
    `QMAE_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(result))

endmodule

bind qm_binary_arith_encoder qmae_checker u_qmae_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .empty  (empty),
    .pop    (pop),
    .result (result)
);

[sim/testbench.sv]
// Self-checking testbench for the QM binary arithmetic encoder.
// Depends on qmae_pkg and qm_binary_arith_encoder from the rtl folder.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import qmae_pkg::*;

    localparam int NCTX     = 256;
    localparam int RUN_CAP  = 65535;
    localparam int WD_LIMIT = 5000;
    localparam int N_RANDOM = 360;

    // Expected run tracker with its own copy of the coder state
    class run_scoreboard;
        logic [16:0] int_a;
        logic [27:0] code;
        logic [3:0]  shift_ct;
        logic [8:0]  held;
        int unsigned ff_stack;
        int unsigned zero_run;
        logic [7:0]  ctx_state [NCTX];
        bit          ovf;
        logic [7:0]  run_val [$];
        int unsigned run_cnt [$];
        out_item_t   runs_due [$];
        int          errors;

        function new();
            coder_init();
            foreach (ctx_state[i]) ctx_state[i] = 8'h00;
            ovf = 0;
            errors = 0;
        endfunction

        function void coder_init();
            int_a = A_INIT;
            code = '0;
            shift_ct = CT_INIT;
            held = NO_BYTE;
            ff_stack = 0;
            zero_run = 0;
        endfunction

        function int unsigned sat_add(int unsigned x, int unsigned y);
            longint unsigned s;
            s = longint'(x) + longint'(y);
            if (s > RUN_CAP)
            begin
                ovf = 1;
                return RUN_CAP;
            end
            return int'(s);
        endfunction

        function void put_run(logic [7:0] b, int unsigned n);
            if (run_val.size() < RUN_MAX && n != 0)
            begin
                run_val.push_back(b);
                run_cnt.push_back(n);
            end
        endfunction

        function void flush_zeros();
            if (zero_run != 0)
            begin
                put_run(8'h00, zero_run);
                zero_run = 0;
            end
        endfunction

        // Release the held byte and the 0xFF stack, with or without carry
        function void release_bytes(bit carry);
            bit have;
            have = !held[8];
            if (carry)
            begin
                if (have)
                begin
                    flush_zeros();
                    put_run(held[7:0] + 8'd1, 1);
                end
                zero_run = sat_add(zero_run, ff_stack);
                ff_stack = 0;
            end
            else
            begin
                if (have && held[7:0] == 8'h00)
                    zero_run = sat_add(zero_run, 1);
                else if (have)
                begin
                    flush_zeros();
                    put_run(held[7:0], 1);
                end
                if (ff_stack != 0)
                begin
                    flush_zeros();
                    put_run(8'hFF, ff_stack);
                    ff_stack = 0;
                end
            end
        endfunction

        function void encode_bit(logic [7:0] ctx, logic b);
            logic [6:0]  idx;
            logic        mps;
            qm_row_t     row;
            logic [16:0] qe;
            logic [8:0]  t;
            idx = ctx_state[ctx][6:0];
            mps = ctx_state[ctx][7];
            if (idx >= QM_ROWS) idx = QM_ROWS - 1;
            row = QM_ROM[idx];
            qe = {1'b0, row.qe};
            int_a = int_a - qe;
            if (b != mps)
            begin
                if (int_a >= qe)
                begin
                    code = code + 28'(int_a);
                    int_a = qe;
                end
                ctx_state[ctx] = {mps ^ row.sw, row.nlps};
            end
            else
            begin
                if (int_a >= A_HALF) return;
                if (int_a < qe)
                begin
                    code = code + 28'(int_a);
                    int_a = qe;
                end
                ctx_state[ctx] = {mps, row.nmps};
            end
            // Renormalize, taking out a byte at each boundary
            do
            begin
                int_a = int_a << 1;
                code = code << 1;
                shift_ct = shift_ct - 4'd1;
                if (shift_ct == 0)
                begin
                    t = code[27:19];
                    if (t > 9'hFF)
                    begin
                        release_bytes(1);
                        held = {1'b0, t[7:0]};
                    end
                    else if (t == 9'hFF)
                        ff_stack = sat_add(ff_stack, 1);
                    else
                    begin
                        release_bytes(0);
                        held = {1'b0, t[7:0]};
                    end
                    code = code & 28'h7FFFF;
                    shift_ct = shift_ct + 4'd8;
                end
            end
            while (int_a < A_HALF && int_a != 0);
        endfunction

        function void finish_segment();
            logic [31:0] t;
            logic [31:0] c;
            t = (32'(int_a) - 32'd1 + 32'(code)) & 32'hFFFF0000;
            c = (t < 32'(code)) ? t + 32'h8000 : t;
            c = c << shift_ct;
            release_bytes((c & 32'hF8000000) != 0);
            if ((c & 32'h7FFF800) != 0)
            begin
                flush_zeros();
                put_run(c[26:19], 1);
                if ((c & 32'h7F800) != 0)
                    put_run(c[18:11], 1);
            end
            coder_init();
        endfunction

        // Note an accepted input item and queue the runs it causes
        function void note_item(in_item_t it);
            out_item_t r;
            run_val.delete();
            run_cnt.delete();
            if (it.op == OP_ENCODE)
                encode_bit(it.ctx_index, it.bit_req);
            else
                finish_segment();
            foreach (run_val[k])
            begin
                r.out_byte = run_val[k];
                r.stuff_zero = (run_val[k] == 8'hFF);
                r.repeat_count = REPEAT_W'(run_cnt[k]);
                r.count_overflow = ovf;
                r.last = (k == run_val.size() - 1);
                runs_due.push_back(r);
            end
        endfunction

        // Check one popped result against the oldest expected run
        function void check_run(out_item_t got);
            out_item_t want;
            if (runs_due.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result %p", $time, got);
                return;
            end
            want = runs_due.pop_front();
            if (got.out_byte !== want.out_byte || got.stuff_zero !== want.stuff_zero ||
                got.repeat_count !== want.repeat_count ||
                got.count_overflow !== want.count_overflow || got.last !== want.last)
            begin
                errors++;
                $display("%0t: mismatch expected %p actual %p", $time, want, got);
            end
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      push;
    in_item_t  item;
    logic      full;
    logic      empty;
    logic      pop;
    out_item_t result;

    run_scoreboard sb;
    int            idle_cycles;
    int            stall_mode;
    int            mode_left;

    qm_binary_arith_encoder u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .item   (item),
        .full   (full),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Sample both handshakes, vary the pop pattern, watch for a hang
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full) sb.note_item(item);
            if (pop && !empty) sb.check_run(result);
            if ((push && !full) || (pop && !empty))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WD_LIMIT)
            begin
                $display("== FAIL ==");
                $finish;
            end
        end
        if (mode_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 300);
        end
        else
            mode_left = mode_left - 1;
        case (stall_mode)
            0: pop <= 1'b1;
            1: pop <= ($urandom_range(0, 1) == 1);
            2: pop <= ($urandom_range(0, 3) == 0);
            default: pop <= (mode_left % 3 != 0);
        endcase
    end

    int burst_left;

    // Hand one item over, following the burst and gap pattern
    task automatic send(input logic op, input logic [7:0] ctx, input logic b);
        in_item_t it;
        int       gap;
        it.op = op;
        it.ctx_index = ctx;
        it.bit_req = b;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0)
            begin
                push <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left = burst_left - 1;
        push <= 1'b1;
        item <= it;
        do @(posedge clk); while (full);
    endtask

    initial
    begin
        int seg_len;
        int skew;
        int count;
        int wait_n;
        logic [7:0] ctx_set [4];
        sb = new();
        rst_n = 1'b0;
        push = 1'b0;
        item = '0;
        pop = 1'b0;
        idle_cycles = 0;
        stall_mode = 0;
        mode_left = 0;
        burst_left = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: finish with nothing to send, edge contexts, both bits
        send(OP_FINISH, 8'h00, 1'b0);
        send(OP_FINISH, 8'hFF, 1'b1);
        for (int i = 0; i < 6; i++) send(OP_ENCODE, 8'h00, 1'b1);
        for (int i = 0; i < 6; i++) send(OP_ENCODE, 8'hFF, i[0]);
        for (int i = 0; i < 6; i++) send(OP_ENCODE, 8'h00, 1'b0);
        send(OP_FINISH, 8'h5A, 1'b1);
        send(OP_ENCODE, 8'hFF, 1'b0);
        send(OP_FINISH, 8'hA5, 1'b0);

        // Random segments of skewed decisions over a few contexts
        count = 0;
        while (count < N_RANDOM)
        begin
            seg_len = $urandom_range(5, 60);
            case ($urandom_range(0, 2))
                0: skew = 3;
                1: skew = 50;
                default: skew = 97;
            endcase
            foreach (ctx_set[i]) ctx_set[i] = 8'($urandom_range(0, 255));
            for (int i = 0; i < seg_len; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                    send(OP_ENCODE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                else
                    send(OP_ENCODE, ctx_set[$urandom_range(0, 3)],
                         ($urandom_range(0, 99) < skew));
                count++;
            end
            send(OP_FINISH, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            count++;
        end
        push <= 1'b0;

        // Drain, then give the core time to show any stray result
        while (sb.runs_due.size() != 0) @(posedge clk);
        wait_n = 0;
        while (wait_n < 100)
        begin
            @(posedge clk);
            wait_n++;
        end
        if (sb.errors == 0 && sb.runs_due.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
